// File: design/bpa_pkg.sv
// Package for the buddy page allocator: status codes, FSM state, command/status structs.
// No dependencies.
`default_nettype none
package bpa_pkg;
    localparam int ORDER_W  = 4;
    localparam int PAGE_W   = 10;
    localparam int STATUS_W = 2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OOM       = 2'd1,
        ST_BAD_ORDER = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_CHECK,
        S_SCAN_RD,
        S_SCAN_WAIT,
        S_SCAN_TEST,
        S_ALLOC_TAKE,
        S_SPLIT,
        S_MERGE_RD,
        S_MERGE_WAIT,
        S_MERGE_TEST,
        S_MERGE_CLR,
        S_FREE_SET,
        S_RESP
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;          // capture request
        logic clear_init;    // start clearing pass
        logic clear_step;    // write one clearing word
        logic scan_init;     // start search at requested order
        logic scan_rd;       // issue read of current scan entry
        logic scan_next;     // advance scan position
        logic take;          // clear found block bit
        logic split;         // one split step
        logic merge_rd;      // read buddy bit
        logic mate_clr;      // clear buddy bit
        logic merge_clr;     // clear self, move up
        logic free_set;      // set final block bit
        logic set_status;    // latch error status
        status_t status;
    } bpa_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_done;
        logic mode;
        logic bad_order;
        logic bad_index;
        logic rd_bit;        // registered memory read data
        logic scan_last;     // scan position is last of whole search
        logic level_last;    // split finished / merge at top
        logic buddy_missing; // buddy index beyond its level
    } bpa_stat_t;
endpackage
`default_nettype wire

// File: design/bpa_if.sv
// Valid/ready channel interface carrying a packed payload word.
// No dependencies.
`default_nettype none
interface bpa_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/buddy_page_allocator.sv
// Top level of the buddy page allocator: controller plus datapath.
// Depends on bpa_pkg, bpa_if, bpa_ctrl, bpa_datapath, bpa_ram.
//
//  channel | dir | word fields
//  req     | in  | mode[0], block_order[4:1], page_index[14:5]
//  rsp     | out | status[1:0], result_page[11:2]
//
// Alloc: a check, then a read, a wait and a test for each bitmap entry scanned (single-port
// RAM, registered read), then a take and one split step per level down to the requested
// order; worst case is an order-0 scan of all 2*PAGE_COUNT-1 entries.
// Free: a check, then per merged level a buddy read, wait, test and two clears (buddy, self), then a last test and set.
// After reset a clearing pass writes all 2*PAGE_COUNT bitmap entries, one per
// cycle, before the first word is taken. One request at a time; a response holds until taken.
`default_nettype none
module buddy_page_allocator import bpa_pkg::*; #(
    parameter int PAGE_COUNT = 1024,
    parameter int LEVELS     = 11
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bpa_if.sink       req,
    bpa_if.source     rsp
);
    bpa_cmd_t  cmd;
    bpa_stat_t stat;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   result_page;

    bpa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready),
        .out_valid(rsp.valid), .out_ready(rsp.ready),
        .stat(stat), .cmd(cmd)
    );

    bpa_datapath #(.PAGE_COUNT(PAGE_COUNT), .LEVELS(LEVELS)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .in_mode(req.data[0]),
        .in_order(req.data[4:1]),
        .in_page(req.data[14:5]),
        .cmd(cmd), .stat(stat),
        .res_status(status), .res_page(result_page)
    );

    assign rsp.data = {result_page, status};
endmodule
`default_nettype wire

// File: design/bpa_ram.sv
// Generic single-port RAM, registered read.
// No dependencies.
`default_nettype none
module bpa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// File: design/bpa_datapath.sv
// Datapath: request registers, level/index walkers, bitmap RAM.
// Depends on bpa_pkg, bpa_ram.
`default_nettype none
module bpa_datapath import bpa_pkg::*; #(
    parameter int PAGE_COUNT = 1024,
    parameter int LEVELS     = 11
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_mode,
    input  wire logic [ORDER_W-1:0]  in_order,
    input  wire logic [PAGE_W-1:0]   in_page,
    input  wire bpa_cmd_t            cmd,
    output bpa_stat_t                stat,
    output logic [STATUS_W-1:0]      res_status,
    output logic [PAGE_W-1:0]        res_page
);
    localparam int DEPTH = 2 * PAGE_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(PAGE_COUNT) + 1;
    localparam int LW    = $clog2(LEVELS + 1);

    logic           mode_reg;
    logic [ORDER_W-1:0] order_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic [LW-1:0]  lvl_reg, lvl_next;
    logic [IW-1:0]  idx_reg, idx_next;
    logic [AW-1:0]  base_reg, base_next;   // first address of level lvl_reg
    logic [AW-1:0]  clr_reg;
    logic           clr_done_reg;
    logic [STATUS_W-1:0] status_reg;

    logic           we;
    logic [AW-1:0]  addr;
    logic           wdata;
    logic           rdata;

    logic [IW-1:0]  lvl_cnt;    // blocks at lvl_reg
    logic [IW-1:0]  mate;
    logic [IW-1:0]  order_mask;
    logic [IW-1:0]  page_ext;
    logic [IW-1:0]  start_idx;
    logic           top_bit;

    bpa_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    assign lvl_cnt    = IW'(PAGE_COUNT) >> lvl_reg;
    assign mate       = idx_reg ^ IW'(1);
    assign page_ext   = IW'(page_reg);
    assign order_mask = (IW'(1) << order_reg) - IW'(1);
    assign start_idx  = page_ext >> order_reg;

    // level base: sum of PAGE_COUNT>>k for k<l = 2*PAGE_COUNT - 2*(PAGE_COUNT>>l)
    function automatic logic [AW-1:0] base_of(input logic [LW-1:0] l);
        logic [AW:0] t;
        t = (AW+1)'(DEPTH) - ((AW+1)'(DEPTH) >> l);
        return t[AW-1:0];
    endfunction

    // top level index of clearing address: reset pattern bit
    assign top_bit = (clr_reg >= base_of(LW'(LEVELS - 1))) &&
                     ({1'b0, clr_reg} < ({1'b0, base_of(LW'(LEVELS - 1))}
                      + (AW+1)'(PAGE_COUNT >> (LEVELS - 1))));

    always_comb
    begin
        we    = 1'b0;
        wdata = 1'b0;
        addr  = base_reg + AW'(idx_reg);
        if (cmd.clear_step)
        begin
            we = 1'b1; addr = clr_reg; wdata = top_bit;
        end
        else if (cmd.take || cmd.merge_clr)
        begin
            we = 1'b1; wdata = 1'b0;
        end
        else if (cmd.mate_clr)
        begin
            we = 1'b1; wdata = 1'b0;
            addr = base_reg + AW'(mate);
        end
        else if (cmd.split)
        begin
            // upper half one level down
            we = 1'b1; wdata = 1'b1;
            addr = base_of(lvl_reg - LW'(1)) + AW'({idx_reg[IW-2:0], 1'b1});
        end
        else if (cmd.merge_rd)
        begin
            addr = base_reg + AW'(mate);
        end
        else if (cmd.free_set)
        begin
            we = 1'b1; wdata = 1'b1;
        end
    end

    always_comb
    begin
        lvl_next  = lvl_reg;
        idx_next  = idx_reg;
        base_next = base_reg;
        if (cmd.scan_init || cmd.load)
        begin
            lvl_next  = LW'(cmd.load ? in_order : order_reg);
            idx_next  = cmd.load ? IW'(0) : (mode_reg ? start_idx : IW'(0));
            base_next = base_of(lvl_next);
        end
        else if (cmd.scan_next)
        begin
            if (idx_reg == lvl_cnt - IW'(1))
            begin
                lvl_next  = lvl_reg + LW'(1);
                idx_next  = '0;
                base_next = base_of(lvl_next);
            end
            else
                idx_next = idx_reg + IW'(1);
        end
        else if (cmd.split)
        begin
            lvl_next  = lvl_reg - LW'(1);
            idx_next  = {idx_reg[IW-2:0], 1'b0};
            base_next = base_of(lvl_next);
        end
        else if (cmd.merge_clr)
        begin
            // buddy already cleared, self bit cleared this cycle
            lvl_next  = lvl_reg + LW'(1);
            idx_next  = idx_reg >> 1;
            base_next = base_of(lvl_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            clr_done_reg <= 1'b0;
        end
        else if (cmd.clear_init)
        begin
            clr_reg      <= '0;
            clr_done_reg <= 1'b0;
        end
        else if (cmd.clear_step)
        begin
            clr_reg      <= clr_reg + AW'(1);
            clr_done_reg <= (clr_reg == AW'(DEPTH - 1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= in_mode;
            order_reg <= in_order;
            page_reg  <= in_page;
            status_reg   <= ST_OK;
        end
        if (cmd.set_status)
            status_reg <= cmd.status;
        lvl_reg  <= lvl_next;
        idx_reg  <= idx_next;
        base_reg <= base_next;
    end

    // result page: index at requested order after splitting, shifted back up
    logic [PAGE_W-1:0] grant_page;
    assign grant_page = PAGE_W'(idx_reg << order_reg);

    assign res_status = status_reg;
    assign res_page   = (status_reg == ST_OK && !mode_reg) ? grant_page : '0;

    assign stat.clear_done    = clr_done_reg;
    assign stat.mode          = mode_reg;
    assign stat.bad_order     = int'(order_reg) > (LEVELS - 1);
    assign stat.bad_index     = ((page_ext & order_mask) != '0) ||
                                (start_idx >= (IW'(PAGE_COUNT) >> order_reg));
    assign stat.rd_bit        = rdata;
    assign stat.scan_last     = (idx_reg == lvl_cnt - IW'(1)) &&
                                (lvl_reg == LW'(LEVELS - 1));
    assign stat.level_last    = mode_reg ? (lvl_reg == LW'(LEVELS - 1))
                                         : (lvl_reg == LW'(order_reg));
    assign stat.buddy_missing = mate >= lvl_cnt;
endmodule
`default_nettype wire

// File: design/bpa_ctrl.sv
// Controller FSM for the buddy page allocator.
// Depends on bpa_pkg.
`default_nettype none
module bpa_ctrl import bpa_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire bpa_stat_t stat,
    output bpa_cmd_t       cmd
);
    state_t state_reg, state_next;
    logic   self_clr_reg, self_clr_next;   // merge: second write (self bit) pending

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            self_clr_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            self_clr_reg <= self_clr_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        self_clr_next = self_clr_reg;
        case (state_reg)
            S_CLEAR:      if (stat.clear_done) state_next = S_IDLE;
            S_IDLE:       if (in_valid) state_next = S_CHECK;
            S_CHECK:
                if (stat.bad_order || (stat.mode && stat.bad_index))
                    state_next = S_RESP;
                else
                    state_next = stat.mode ? S_MERGE_RD : S_SCAN_RD;
            S_SCAN_RD:    state_next = S_SCAN_WAIT;
            S_SCAN_WAIT:  state_next = S_SCAN_TEST;
            S_SCAN_TEST:
                if (stat.rd_bit)        state_next = S_ALLOC_TAKE;
                else if (stat.scan_last) state_next = S_RESP;
                else                    state_next = S_SCAN_RD;
            S_ALLOC_TAKE: state_next = stat.level_last ? S_RESP : S_SPLIT;
            S_SPLIT:      state_next = stat.level_last ? S_RESP : S_SPLIT;
            S_MERGE_RD:
                if (stat.level_last || stat.buddy_missing) state_next = S_FREE_SET;
                else state_next = S_MERGE_WAIT;
            S_MERGE_WAIT: state_next = S_MERGE_TEST;
            S_MERGE_TEST: state_next = stat.rd_bit ? S_MERGE_CLR : S_FREE_SET;
            S_MERGE_CLR:
            begin
                self_clr_next = !self_clr_reg;
                state_next    = self_clr_reg ? S_MERGE_RD : S_MERGE_CLR;
            end
            S_FREE_SET:   state_next = S_RESP;
            S_RESP:       if (out_ready) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.status = ST_OK;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_CLEAR:
                cmd.clear_step = !stat.clear_done;
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_CHECK:
            begin
                cmd.scan_init = 1'b1;
                if (stat.bad_order)
                begin
                    cmd.set_status = 1'b1; cmd.status = ST_BAD_ORDER;
                end
                else if (stat.mode && stat.bad_index)
                begin
                    cmd.set_status = 1'b1; cmd.status = ST_BAD_INDEX;
                end
            end
            S_SCAN_RD:    ;
            S_SCAN_WAIT:  ;
            S_SCAN_TEST:
                if (!stat.rd_bit)
                begin
                    if (stat.scan_last)
                    begin
                        cmd.set_status = 1'b1; cmd.status = ST_OOM;
                    end
                    else
                        cmd.scan_next = 1'b1;
                end
            S_ALLOC_TAKE: cmd.take = 1'b1;
            S_SPLIT:      cmd.split = !stat.level_last;
            S_MERGE_RD:   cmd.merge_rd = !(stat.level_last || stat.buddy_missing);
            S_MERGE_WAIT: cmd.merge_rd = 1'b1;
            S_MERGE_TEST: ;
            S_MERGE_CLR:
                if (self_clr_reg) cmd.merge_clr = 1'b1;  // self bit, then move up
                else              cmd.mate_clr  = 1'b1;  // buddy bit
            S_FREE_SET:   cmd.free_set = 1'b1;
            S_RESP:       out_valid = 1'b1;
            default:      ;
        endcase
    end
endmodule
`default_nettype wire
